/* src/rfd_pkg.sv */
package rfd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int FRAME_LIMIT = MAX_PAYLOAD + 2;
  localparam int COUNT_W = $clog2(FRAME_LIMIT + 1);
  localparam int LEN_W = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CODE_START = 8'h01;
  localparam logic [7:0] CODE_END   = 8'h04;
  localparam logic [7:0] CODE_ESC   = 8'h10;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_STATUS  = 1'b1;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    TK_DATA,
    TK_START,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
  } token_t;

  localparam logic [15:0] NIB_TABLE [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
    16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
  };

  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
    logic [3:0] idx;
    idx = crc[15:12] ^ nib;
    return NIB_TABLE[idx] ^ {crc[11:0], 4'h0};
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] mid;
    mid = crc_nibble(crc, b[7:4]);
    return crc_nibble(mid, b[3:0]);
  endfunction

endpackage

/* src/rfd_front.sv */
module rfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  output logic            tok_valid,
  output rfd_pkg::token_t tok,
  input  logic            tok_ready
);
  import rfd_pkg::*;

  logic esc_pending_r;
  logic esc_pending_nxt;
  logic accept;

  assign in_ready = tok_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    esc_pending_nxt = esc_pending_r;
    tok_valid = 1'b0;
    tok.kind = TK_DATA;
    tok.data = in_rx_byte;
    if (accept) begin
      if (esc_pending_r) begin
        esc_pending_nxt = 1'b0;
        tok_valid = 1'b1;
      end else if (in_rx_byte == CODE_ESC) begin
        esc_pending_nxt = 1'b1;
      end else if (in_rx_byte == CODE_START) begin
        tok_valid = 1'b1;
        tok.kind = TK_START;
      end else if (in_rx_byte == CODE_END) begin
        tok_valid = 1'b1;
        tok.kind = TK_END;
      end else begin
        tok_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pending_r <= 1'b0;
    end else begin
      esc_pending_r <= esc_pending_nxt;
    end
  end

endmodule

/* src/rfd_fifo.sv */
module rfd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  rfd_pkg::token_t push_tok,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rfd_pkg::token_t pop_tok
);
  import rfd_pkg::*;

  token_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

/* src/rfd_back.sv */
module rfd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     tok_valid,
  output logic                     tok_ready,
  input  rfd_pkg::token_t          tok,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [7:0]               out_payload_byte,
  output logic [1:0]               out_frame_status,
  output logic [rfd_pkg::LEN_W-1:0] out_payload_length
);
  import rfd_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         older_r, older_nxt;
  logic [7:0]         newer_r, newer_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               pop;
  logic [COUNT_W-1:0] len_full;

  assign pop = tok_valid && (!out_valid_r || out_ready);
  assign tok_ready = pop;
  assign len_full = count_r - COUNT_W'(2);

  always_comb begin
    count_nxt  = count_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    crc_nxt    = crc_r;
    ovf_nxt    = ovf_r;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    len_nxt    = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      case (tok.kind)
        TK_START: begin
          count_nxt = '0;
          older_nxt = '0;
          newer_nxt = '0;
          crc_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        TK_END: begin
          out_valid_nxt = 1'b1;
          kind_nxt = RK_STATUS;
          byte_nxt = '0;
          len_nxt  = '0;
          if (ovf_r) begin
            status_nxt = ST_OVERFLOW;
          end else if (count_r <= COUNT_W'(2)) begin
            status_nxt = ST_SHORT;
          end else if ({newer_r, older_r} == crc_r) begin
            status_nxt = ST_GOOD;
            len_nxt = LEN_W'(len_full);
          end else begin
            status_nxt = ST_CRC_BAD;
          end
          count_nxt = '0;
          older_nxt = '0;
          newer_nxt = '0;
          crc_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        TK_DATA: begin
          if (count_r >= COUNT_W'(FRAME_LIMIT)) begin
            ovf_nxt = 1'b1;
          end else begin
            if (count_r >= COUNT_W'(2)) begin
              out_valid_nxt = 1'b1;
              kind_nxt   = RK_PAYLOAD;
              byte_nxt   = older_r;
              status_nxt = ST_GOOD;
              len_nxt    = '0;
              crc_nxt    = crc_byte(crc_r, older_r);
            end
            older_nxt = newer_r;
            newer_nxt = tok.data;
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      older_r     <= '0;
      newer_r     <= '0;
      crc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      crc_r       <= crc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    len_r    <= len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_frame_status   = status_r;
  assign out_payload_length = len_r;

endmodule

/* src/reply_frame_deframer_crc16_core.sv */
// path: a word accepted at the input is written into the token queue, and the result it causes is
//   then registered in the frame engine's output register, with an empty queue and a free output
// throughput: one word per cycle, sustained while results are taken; the token queue
//   between decoder and frame engine (four entries) absorbs short output stalls
// reset: synchronous active-low rst_n clears escape, queue, frame count, crc and output valid
module reply_frame_deframer_crc16_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_result_kind,
  output logic [7:0]                out_payload_byte,
  output logic [1:0]                out_frame_status,
  output logic [rfd_pkg::LEN_W-1:0] out_payload_length
);
  import rfd_pkg::*;

  logic   fr_valid;
  logic   fr_ready;
  token_t fr_tok;
  logic   bk_valid;
  logic   bk_ready;
  token_t bk_tok;

  rfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .tok_valid (fr_valid),
    .tok       (fr_tok),
    .tok_ready (fr_ready)
  );

  rfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_tok  (fr_tok),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_tok   (bk_tok)
  );

  rfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (bk_valid),
    .tok_ready         (bk_ready),
    .tok               (bk_tok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_status  (out_frame_status),
    .out_payload_length(out_payload_length)
  );

`ifndef SYNTHESIS
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_PAYLOAD |->
      out_frame_status == ST_GOOD && out_payload_length == '0)
    else $error("payload word carries status fields");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_STATUS && out_frame_status != ST_GOOD |->
      out_payload_length == '0 && out_payload_byte == '0)
    else $error("failed frame reports a length");

  a_good_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_STATUS && out_frame_status == ST_GOOD |->
      out_payload_length != '0 && out_payload_length <= LEN_W'(MAX_PAYLOAD))
    else $error("good frame length out of range");
`endif

endmodule
